@@ hw/rtl/ptgf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptgf_pkg
// Shared sizes, field types and command codes of the palette table with
// gradient fill.
// ----------------------------------------------------------------------------
package ptgf_pkg;

	localparam int TABLE_DEPTH  = 256;
	localparam int CHANNEL_BITS = 16;

	localparam int ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W  = $clog2(CHANNEL_BITS);
	localparam int ENTRY_W = 3 * CHANNEL_BITS;

	// Item field widths
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 9;
	localparam int IN_CH_W = 16;
	localparam int OUT_W   = 17;
	localparam int MAX_W   = 16;

	// Configuration register
	localparam int REG_W       = 9;
	localparam int REG_RESET   = 256;
	localparam int PADDR_W     = 2;
	localparam int PDATA_W     = 32;

	typedef logic [CMD_W-1:0]        cmd_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [IN_CH_W-1:0]      in_chan_t;
	typedef logic signed [OUT_W-1:0] out_chan_t;
	typedef logic [MAX_W-1:0]        max_t;
	typedef logic [CHANNEL_BITS-1:0] chan_t;

	localparam cmd_t CMD_WRITE  = 3'd0;
	localparam cmd_t CMD_READ   = 3'd1;
	localparam cmd_t CMD_GRAD   = 3'd2;
	localparam cmd_t CMD_MAX    = 3'd3;
	localparam cmd_t CMD_INVERT = 3'd4;

	localparam logic [PADDR_W-1:0] ADDR_ENTRIES = 2'd0;

	// Distance between two channel values.
	function automatic chan_t abs_diff(input chan_t a, input chan_t b);
		return (b >= a) ? chan_t'(b - a) : chan_t'(a - b);
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ptgf_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptgf_req_if / ptgf_rsp_if
// Command and result channels of the palette table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptgf_req_if;
	logic                valid;
	logic                ready;
	ptgf_pkg::cmd_t      command;
	ptgf_pkg::idx_t      index;
	ptgf_pkg::idx_t      end_index;
	ptgf_pkg::in_chan_t  red;
	ptgf_pkg::in_chan_t  green;
	ptgf_pkg::in_chan_t  blue;
	ptgf_pkg::in_chan_t  end_red;
	ptgf_pkg::in_chan_t  end_green;
	ptgf_pkg::in_chan_t  end_blue;
	ptgf_pkg::in_chan_t  inv_limit;

	modport source (output valid, command, index, end_index, red, green, blue,
		end_red, end_green, end_blue, inv_limit, input ready);
	modport sink (input valid, command, index, end_index, red, green, blue,
		end_red, end_green, end_blue, inv_limit, output ready);
endinterface

interface ptgf_rsp_if;
	logic                valid;
	logic                ready;
	ptgf_pkg::out_chan_t out_red;
	ptgf_pkg::out_chan_t out_green;
	ptgf_pkg::out_chan_t out_blue;
	ptgf_pkg::max_t      out_max;
	logic                status;

	modport source (output valid, out_red, out_green, out_blue, out_max, status,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_max, status,
		output ready);
endinterface
`default_nettype wire

@@ hw/rtl/palette_table_gradient_fill_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// palette_table_gradient_fill_top
// RGB palette with write, read, linear gradient fill, invert and max query,
// run by a small sequencer around one table memory and a shared divider.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | carries
//  --------+-----+---------------------+-----------------------------------
//  req     | in  | valid/ready         | command, positions, colours, maximum
//  rsp     | out | valid/ready         | read colour, max value, status
//  apb     | in  | psel/penable/pready | entries_in_use at byte 0
//
//  A max query reads the n entries in use and a gradient writes every entry
//  from index to end_index, both one entry a cycle through the table memory
//  port; a gradient first runs the bit-serial divider once per channel.
//  Reset clears a valid bit per entry; an invalid entry reads as zero, so no
//  clearing pass is needed. Lowering entries_in_use drops the valid bits of
//  entries above the new count.
//  A finished result waits in the output register; the next item is taken
//  meanwhile and only its own completion stalls on a full output register.
// ----------------------------------------------------------------------------
module palette_table_gradient_fill_top (
	input  wire                           clk,
	input  wire                           arst_n,
	ptgf_req_if.sink                      req,
	ptgf_rsp_if.source                    rsp,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [ptgf_pkg::PADDR_W-1:0]   paddr,
	input  wire [ptgf_pkg::PDATA_W-1:0]   pwdata,
	output logic [ptgf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ptgf_pkg::*;

	// Sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_ENTRY  = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_MAX    = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CHANNEL_BITS - 1);

	logic [2:0]        state_q;

	// Configuration
	logic [REG_W-1:0]  entries_q;
	logic              cfg_wr;
	logic [CNT_W-1:0]  cfg_count;
	logic [CNT_W-1:0]  live_count;

	// Latched item
	cmd_t              cmd_q;
	idx_t              idx_q;
	idx_t              eidx_q;
	chan_t             c1_q [3];
	chan_t             c2_q [3];
	chan_t             mx_q;
	logic [CNT_W-1:0]  n_q;

	// Table memory and valid bits
	logic [ENTRY_W-1:0] mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [ENTRY_W-1:0] rd_data_q;
	logic              rd_vld_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	chan_t             ent [3];
	logic              inv_ok;

	// Divider and gradient walk
	logic [1:0]        ch_q;
	logic [STEP_W-1:0] step_q;
	chan_t             dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  span_q;
	logic [CNT_W:0]    div_try;
	logic              div_ge;
	logic [CNT_W-1:0]  div_rem;
	logic              dneg_q [3];
	chan_t             dq_q [3];
	logic [CNT_W-1:0]  dr_q [3];
	chan_t             qacc_q [3];
	logic [CNT_W-1:0]  racc_q [3];
	chan_t             grad [3];
	logic [CNT_W:0]    r_sum [3];
	logic              r_wrap [3];
	logic [CNT_W-1:0]  ptr_q;

	// Max query
	chan_t             best_q;
	chan_t             best_n;

	// Result staging and output register
	out_chan_t         res_ch_q [3];
	max_t              res_max_q;
	logic              res_status_q;
	logic              out_valid_q;
	out_chan_t         out_ch_q [3];
	max_t              out_max_q;
	logic              out_status_q;
	logic              out_load;

	// ------------------------------------------------------------------
	// APB register
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign prdata    = (paddr == ADDR_ENTRIES) ? PDATA_W'(entries_q) : '0;
	assign cfg_count = (pwdata[REG_W-1:0] >= REG_W'(TABLE_DEPTH)) ?
		CNT_W'(TABLE_DEPTH) : CNT_W'(pwdata[REG_W-1:0]);
	assign live_count = (entries_q >= REG_W'(TABLE_DEPTH)) ?
		CNT_W'(TABLE_DEPTH) : CNT_W'(entries_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= REG_W'(REG_RESET);
		end else if (cfg_wr) begin
			entries_q <= pwdata[REG_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Handshake
	// ------------------------------------------------------------------
	assign req.ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// ------------------------------------------------------------------
	// Table read and write selection
	// ------------------------------------------------------------------
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ent[c] = rd_vld_q ? rd_data_q[c*CHANNEL_BITS +: CHANNEL_BITS] : '0;
		end
	end

	assign inv_ok = (mx_q >= ent[0]) && (mx_q >= ent[1]) && (mx_q >= ent[2]);

	always_comb begin
		rd_addr = idx_q[ADDR_W-1:0];
		if (state_q == S_DECODE && cmd_q == CMD_MAX) begin
			rd_addr = '0;
		end else if (state_q == S_MAX) begin
			rd_addr = ptr_q[ADDR_W-1:0];
		end
	end

	// Gradient lanes: value at offset k is start +/- floor-or-ceil of |d|*k/span,
	// kept as quotient and remainder stepped by |d|/span and |d|%span.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			grad[c] = dneg_q[c] ?
				chan_t'(c1_q[c] - qacc_q[c] - chan_t'(racc_q[c] != '0)) :
				chan_t'(c1_q[c] + qacc_q[c]);
			r_sum[c]  = {1'b0, racc_q[c]} + {1'b0, dr_q[c]};
			r_wrap[c] = r_sum[c] >= {1'b0, span_q};
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[ADDR_W-1:0];
		wr_data = {c1_q[2], c1_q[1], c1_q[0]};
		case (state_q)
			S_DECODE: begin
				wr_en = (cmd_q == CMD_WRITE) && (idx_q < n_q);
			end
			S_ENTRY: begin
				wr_en   = (cmd_q == CMD_INVERT) && inv_ok;
				wr_data = {chan_t'(mx_q - ent[2]), chan_t'(mx_q - ent[1]),
					chan_t'(mx_q - ent[0])};
			end
			S_WALK: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[ADDR_W-1:0];
				wr_data = {grad[2], grad[1], grad[0]};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
		rd_vld_q  <= valid_q[rd_addr];
	end

	// Valid bits: set on write, drop above a lowered count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (wr_en && wr_addr == ADDR_W'(i)) begin
					valid_q[i] <= 1'b1;
				end else if (cfg_wr && CNT_W'(i) >= cfg_count) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared divider: one quotient bit a cycle
	// ------------------------------------------------------------------
	assign div_try = {rem_q, dvd_q[CHANNEL_BITS-1]};
	assign div_ge  = div_try >= {1'b0, span_q};
	assign div_rem = div_ge ? CNT_W'(div_try - {1'b0, span_q}) : CNT_W'(div_try);

	// Max fold
	always_comb begin
		best_n = best_q;
		for (int c = 0; c < 3; c++) begin
			if (ent[c] > best_n) begin
				best_n = ent[c];
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					case (cmd_q)
						CMD_READ, CMD_INVERT:
							state_q <= (idx_q < n_q) ? S_ENTRY : S_DONE;
						CMD_GRAD:
							state_q <= (idx_q < eidx_q && eidx_q < n_q) ? S_DIV : S_DONE;
						CMD_MAX:
							state_q <= (n_q == '0) ? S_DONE : S_MAX;
						default:
							state_q <= S_DONE;
					endcase
				end
				S_ENTRY: begin
					state_q <= S_DONE;
				end
				S_DIV: begin
					if (step_q == STEP_LAST && ch_q == 2'd2) state_q <= S_WALK;
				end
				S_WALK: begin
					if (ptr_q == CNT_W'(eidx_q)) state_q <= S_DONE;
				end
				S_MAX: begin
					if (ptr_q == n_q) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				// Latch the item and the count in effect.
				cmd_q  <= req.command;
				idx_q  <= req.index;
				eidx_q <= req.end_index;
				c1_q[0] <= req.red[CHANNEL_BITS-1:0];
				c1_q[1] <= req.green[CHANNEL_BITS-1:0];
				c1_q[2] <= req.blue[CHANNEL_BITS-1:0];
				c2_q[0] <= req.end_red[CHANNEL_BITS-1:0];
				c2_q[1] <= req.end_green[CHANNEL_BITS-1:0];
				c2_q[2] <= req.end_blue[CHANNEL_BITS-1:0];
				mx_q    <= req.inv_limit[CHANNEL_BITS-1:0];
				n_q     <= live_count;
			end
			S_DECODE: begin
				for (int c = 0; c < 3; c++) begin
					// Out of range read gives all ones on every channel.
					res_ch_q[c] <= (cmd_q == CMD_READ && !(idx_q < n_q)) ? '1 : '0;
					dneg_q[c]   <= c2_q[c] < c1_q[c];
				end
				res_max_q    <= '0;
				best_q       <= '0;
				ptr_q        <= CNT_W'(1);
				span_q       <= CNT_W'(eidx_q - idx_q);
				ch_q         <= 2'd0;
				step_q       <= '0;
				rem_q        <= '0;
				dvd_q        <= abs_diff(c1_q[0], c2_q[0]);
				case (cmd_q)
					CMD_WRITE, CMD_INVERT, CMD_READ: begin
						res_status_q <= !(idx_q < n_q);
					end
					CMD_GRAD: begin
						res_status_q <= !(idx_q < eidx_q && eidx_q < n_q);
					end
					CMD_MAX: begin
						res_status_q <= 1'b0;
					end
					default: begin
						res_status_q <= 1'b1;
					end
				endcase
			end
			S_ENTRY: begin
				if (cmd_q == CMD_READ) begin
					for (int c = 0; c < 3; c++) res_ch_q[c] <= OUT_W'(ent[c]);
				end else begin
					res_status_q <= !inv_ok;
				end
			end
			S_DIV: begin
				if (step_q == STEP_LAST) begin
					dq_q[ch_q] <= {dvd_q[CHANNEL_BITS-2:0], div_ge};
					dr_q[ch_q] <= div_rem;
					step_q     <= '0;
					rem_q      <= '0;
					if (ch_q == 2'd2) begin
						// Divisions done: start the walk at the first position.
						ptr_q <= CNT_W'(idx_q);
						for (int c = 0; c < 3; c++) begin
							qacc_q[c] <= '0;
							racc_q[c] <= '0;
						end
					end else begin
						ch_q  <= ch_q + 2'd1;
						dvd_q <= abs_diff(c1_q[ch_q + 2'd1], c2_q[ch_q + 2'd1]);
					end
				end else begin
					rem_q  <= div_rem;
					dvd_q  <= {dvd_q[CHANNEL_BITS-2:0], div_ge};
					step_q <= step_q + STEP_W'(1);
				end
			end
			S_WALK: begin
				ptr_q <= ptr_q + CNT_W'(1);
				for (int c = 0; c < 3; c++) begin
					qacc_q[c] <= chan_t'(qacc_q[c] + dq_q[c] + chan_t'(r_wrap[c]));
					racc_q[c] <= r_wrap[c] ? CNT_W'(r_sum[c] - {1'b0, span_q}) :
						CNT_W'(r_sum[c]);
				end
			end
			S_MAX: begin
				best_q <= best_n;
				ptr_q  <= ptr_q + CNT_W'(1);
				if (ptr_q == n_q) res_max_q <= MAX_W'(best_n);
			end
			default: begin
				best_q <= best_q;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q     <= res_ch_q;
			out_max_q    <= res_max_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_red   = out_ch_q[0];
	assign rsp.out_green = out_ch_q[1];
	assign rsp.out_blue  = out_ch_q[2];
	assign rsp.out_max   = out_max_q;
	assign rsp.status    = out_status_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == S_DECODE)
		else $error("accepted item did not enter decode");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> ptr_q <= CNT_W'(eidx_q) && ptr_q >= CNT_W'(idx_q))
		else $error("gradient walk left its range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < span_q)
		else $error("divider remainder not below span");

	a_walk_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> racc_q[0] < span_q && racc_q[1] < span_q &&
			racc_q[2] < span_q)
		else $error("gradient remainder not below span");

	a_max_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAX |-> ptr_q != '0 && ptr_q <= n_q)
		else $error("max query pointer out of range");

endmodule
`default_nettype wire
